// ----- hdl/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON string unescape package
// Item types, result codes and the UTF-8 encoder shared by the unescape block.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_UNTERMINATED = 3'd1,
    ERR_ESCAPE       = 3'd2,
    ERR_HEX          = 3'd3,
    ERR_LOW          = 3'd4
  } err_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
    logic [7:0] close_quote;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    err_t       error_kind;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [CntW-1:0]             cnt;
    logic [MaxResults-1:0][7:0]  bytes;
  } utf8_t;

  typedef struct packed {
    logic [CntW-1:0]             cnt;
    logic [MaxResults-1:0][7:0]  bytes;
    kind_t                       kind;
    err_t                        err;
  } grp_t;

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    priority if (cp <= 21'h00007F) begin
      r.cnt      = CntW'(1);
      r.bytes[0] = cp[7:0];
    end else if (cp <= 21'h0007FF) begin
      r.cnt      = CntW'(2);
      r.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
      r.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
    end else if (cp <= 21'h00FFFF) begin
      r.cnt      = CntW'(3);
      r.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
      r.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      r.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
    end else begin
      r.cnt      = CntW'(4);
      r.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
      r.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
      r.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
      r.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
    end
    return r;
  endfunction

endpackage

// ----- hdl/jsu_decode.sv -----
// ----------------------------------------------------------------------------
// JSON string unescape decoder
// Holds the escape state and turns one registered item into a result group.
// ----------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_item_t item,
  input  logic     adv,
  output grp_t     grp
);

  typedef enum logic [5:0] {
    MODE_NORMAL    = 6'b000001,
    MODE_ESC       = 6'b000010,
    MODE_HEX_FIRST = 6'b000100,
    MODE_WANT_BS   = 6'b001000,
    MODE_WANT_U    = 6'b010000,
    MODE_HEX_LOW   = 6'b100000
  } mode_t;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChU      = 8'h75;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hc_r, hc_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [9:0]  hs_r, hs_nxt;

  logic        hex_ok;
  logic [3:0]  hex_v;
  logic [15:0] code;
  logic        fin;
  kind_t       fin_kind;
  err_t        fin_err;
  utf8_t       enc;
  logic        enc_en;
  logic [20:0] enc_cp;

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'h0;
    if (item.char_in >= 8'h30 && item.char_in <= 8'h39) begin
      hex_v = item.char_in[3:0];
    end else if ((item.char_in >= 8'h61 && item.char_in <= 8'h66) ||
                 (item.char_in >= 8'h41 && item.char_in <= 8'h46)) begin
      hex_v = item.char_in[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign code = {acc_r[11:0], hex_v};
  assign enc  = utf8_encode(enc_cp);

  always_comb begin
    grp      = '0;
    mode_nxt = mode_r;
    hc_nxt   = hc_r;
    acc_nxt  = acc_r;
    hs_nxt   = hs_r;
    fin      = 1'b0;
    fin_kind = KIND_ERROR;
    fin_err  = ERR_NONE;
    enc_en   = 1'b0;
    enc_cp   = {5'b00000, code};

    unique case (mode_r)
      MODE_ESC: begin
        if (item.end_of_input) begin
          fin     = 1'b1;
          fin_err = ERR_ESCAPE;
        end else begin
          grp.cnt  = CntW'(1);
          mode_nxt = MODE_NORMAL;
          unique case (item.char_in)
            ChQuote:  grp.bytes[0] = 8'h22;
            ChBslash: grp.bytes[0] = 8'h5C;
            ChSlash:  grp.bytes[0] = 8'h2F;
            ChB:      grp.bytes[0] = 8'h08;
            ChF:      grp.bytes[0] = 8'h0C;
            ChN:      grp.bytes[0] = 8'h0A;
            ChR:      grp.bytes[0] = 8'h0D;
            ChT:      grp.bytes[0] = 8'h09;
            ChU: begin
              grp.cnt  = '0;
              mode_nxt = MODE_HEX_FIRST;
              hc_nxt   = 2'd0;
              acc_nxt  = '0;
            end
            default: begin
              fin     = 1'b1;
              fin_err = ERR_ESCAPE;
            end
          endcase
        end
      end
      MODE_HEX_FIRST, MODE_HEX_LOW: begin
        if (item.end_of_input || !hex_ok) begin
          fin     = 1'b1;
          fin_err = ERR_HEX;
        end else if (hc_r != 2'd3) begin
          acc_nxt = code;
          hc_nxt  = hc_r + 2'd1;
        end else begin
          acc_nxt = '0;
          hc_nxt  = 2'd0;
          if (mode_r == MODE_HEX_FIRST) begin
            if (code >= 16'hD800 && code <= 16'hDBFF) begin
              hs_nxt   = code[9:0];
              mode_nxt = MODE_WANT_BS;
            end else begin
              enc_en   = 1'b1;
              mode_nxt = MODE_NORMAL;
            end
          end else if (code < 16'hDC00 || code > 16'hDFFF) begin
            fin     = 1'b1;
            fin_err = ERR_LOW;
          end else begin
            enc_en   = 1'b1;
            enc_cp   = {11'(hs_r) + 11'd64, code[9:0]};
            mode_nxt = MODE_NORMAL;
            hs_nxt   = '0;
          end
        end
      end
      MODE_WANT_BS: begin
        if (item.end_of_input || item.char_in != ChBslash) begin
          fin     = 1'b1;
          fin_err = ERR_LOW;
        end else begin
          mode_nxt = MODE_WANT_U;
        end
      end
      MODE_WANT_U: begin
        if (item.end_of_input || item.char_in != ChU) begin
          fin     = 1'b1;
          fin_err = ERR_LOW;
        end else begin
          mode_nxt = MODE_HEX_LOW;
          hc_nxt   = 2'd0;
          acc_nxt  = '0;
        end
      end
      default: begin
        if (item.end_of_input) begin
          fin     = 1'b1;
          fin_err = ERR_UNTERMINATED;
        end else if (item.char_in == item.close_quote) begin
          fin      = 1'b1;
          fin_kind = KIND_DONE;
        end else if (item.char_in == ChBslash) begin
          mode_nxt = MODE_ESC;
        end else begin
          mode_nxt     = MODE_NORMAL;
          grp.cnt      = CntW'(1);
          grp.bytes[0] = item.char_in;
        end
      end
    endcase

    if (enc_en) begin
      grp.cnt   = enc.cnt;
      grp.bytes = enc.bytes;
    end

    if (fin) begin
      grp.cnt   = CntW'(1);
      grp.bytes = '0;
      grp.kind  = fin_kind;
      grp.err   = fin_err;
      mode_nxt  = MODE_NORMAL;
      hc_nxt    = '0;
      acc_nxt   = '0;
      hs_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      hc_r   <= '0;
      acc_r  <= '0;
      hs_r   <= '0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      hc_r   <= hc_nxt;
      acc_r  <= acc_nxt;
      hs_r   <= hs_nxt;
    end
  end

endmodule

// ----- hdl/jsu_out_buf.sv -----
// ----------------------------------------------------------------------------
// JSON string unescape result buffer
// Holds one result group and hands its items out one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module jsu_out_buf import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  grp_t      grp,
  input  logic      load,
  output logic      free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic [CntW-1:0]            cnt_r, cnt_nxt;
  logic [MaxResults-1:0][7:0] bytes_r, bytes_nxt;
  kind_t                      kind_r;
  err_t                       err_r;
  logic                       pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign free      = (cnt_r == '0) || (pop && cnt_r == CntW'(1));

  assign out_item.out_byte   = bytes_r[0];
  assign out_item.kind       = kind_r;
  assign out_item.error_kind = err_r;
  assign out_item.last       = (cnt_r == CntW'(1));

  always_comb begin
    cnt_nxt   = cnt_r;
    bytes_nxt = bytes_r;
    if (load) begin
      cnt_nxt   = grp.cnt;
      bytes_nxt = grp.bytes;
    end else if (pop) begin
      cnt_nxt   = cnt_r - CntW'(1);
      bytes_nxt = {8'h00, bytes_r[MaxResults-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    if (load) begin
      kind_r <= grp.kind;
      err_r  <= grp.err;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxResults))
    else $error("result count out of range");

  a_final_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind != KIND_DATA |-> out_item.last)
    else $error("completion or error item is not the last of its group");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> cnt_r == '0 || (pop && cnt_r == CntW'(1)))
    else $error("group loaded over pending items");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !load && cnt_r > CntW'(1) |=> out_valid)
    else $error("group lost items while draining");

endmodule

// ----- hdl/json_string_unescape_utf8.sv -----
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Decodes a JSON string body, one character per item, into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Usage: feed the characters that follow the opening quote on the in_
// channel, one item per character, with the closing quote byte in
// close_quote. Each item yields zero to four result items on the out_
// channel: data bytes, a completion item, or an error item. The final
// result item caused by an input item has last set.
// An input item is taken into an input register, decoded from there into
// a result group register once that register is free, and its results are
// driven out of that register. Items that yield at most one result flow at
// one item per cycle while out_stall is low. A group of more than one result
// holds the result register until it drains, so in_stall rises while it
// drains. A completion or an error returns the decoder to its reset state.
// Reset empties both registers and puts the decoder in normal character
// mode. When out_stall is high, the current result holds and the input
// side keeps taking items only until the input register is full.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic     in_valid_r;
  in_item_t in_item_r;
  logic     accept;
  logic     adv;
  logic     free;
  grp_t     grp;

  assign adv      = in_valid_r && free;
  assign in_stall = in_valid_r && !free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (accept) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_item;
    end
  end

  jsu_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (in_item_r),
    .adv   (adv),
    .grp   (grp)
  );

  jsu_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp       (grp),
    .load      (adv),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// JSON string unescape testbench
// Drives a directed table and then random string bodies into the decoder,
// with random gaps and stalls on both sides, and compares every result item
// with the expected item of its table row or the decoder model held here.
// ----------------------------------------------------------------------------
module tb_top;
  import jsu_pkg::*;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam int unsigned NumDirRows = 27;
  localparam int unsigned NumRandItems = 450;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned HoldAfter = 150;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxPrinted = 40;

  localparam logic [7:0] EscLetters [8] = '{8'h22, 8'h5C, 8'h2F, "b", "f", "n", "r", "t"};
  localparam logic [15:0] BoundaryCodes [10] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                                 16'h0800, 16'hD7FF, 16'hDC00, 16'hDFFF,
                                                 16'hE000, 16'hFFFF};

  typedef enum logic [2:0] {
    ST_NORMAL,
    ST_ESC,
    ST_HEX_FIRST,
    ST_WANT_BS,
    ST_WANT_U,
    ST_HEX_LOW
  } dec_state_t;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t exp;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  dec_state_t  dec_mode = ST_NORMAL;
  logic [1:0]  hex_digits = '0;
  logic [15:0] hex_accum = '0;
  logic [9:0]  hi_surr = '0;

  out_item_t step_q[$];
  out_item_t expected_decode_q[$];
  stim_row_t stim_q[$];
  stim_row_t dir_rows [NumDirRows];
  logic [7:0] cur_quote;

  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;

  json_string_unescape_utf8 dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("mismatch at cycle %0d, result %0d: %s", cycles, results_seen, msg);
    end
  endtask

  // Decoder model.
  function automatic void clear_decoder();
    dec_mode = ST_NORMAL;
    hex_digits = '0;
    hex_accum = '0;
    hi_surr = '0;
  endfunction

  function automatic void add_result(input logic [7:0] b, input kind_t k, input err_t e);
    out_item_t r;
    r.out_byte = b;
    r.kind = k;
    r.error_kind = e;
    r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void end_string(input kind_t k, input err_t e);
    add_result(8'h00, k, e);
    clear_decoder();
  endfunction

  function automatic void add_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_result(cp[7:0], KIND_DATA, ERR_NONE);
    end else if (cp < 21'h800) begin
      add_result({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
      add_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end else if (cp < 21'h10000) begin
      add_result({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
      add_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
      add_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end else begin
      add_result({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
      add_result({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
      add_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
      add_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end
  endfunction

  function automatic void decode_char(input in_item_t it);
    logic [7:0] c;
    logic [7:0] esc;
    logic [3:0] nib;
    logic [15:0] code;
    bit is_hex;
    c = it.char_in;
    step_q.delete();
    case (dec_mode)
      ST_ESC: begin
        if (it.end_of_input) begin
          end_string(KIND_ERROR, ERR_ESCAPE);
        end else if (c == "u") begin
          dec_mode = ST_HEX_FIRST;
          hex_digits = '0;
          hex_accum = '0;
        end else if (c inside {8'h22, CH_BSLASH, 8'h2F, "b", "f", "n", "r", "t"}) begin
          case (c)
            "b": esc = 8'h08;
            "f": esc = 8'h0C;
            "n": esc = 8'h0A;
            "r": esc = 8'h0D;
            "t": esc = 8'h09;
            default: esc = c;
          endcase
          add_result(esc, KIND_DATA, ERR_NONE);
          dec_mode = ST_NORMAL;
        end else begin
          end_string(KIND_ERROR, ERR_ESCAPE);
        end
      end
      ST_HEX_FIRST, ST_HEX_LOW: begin
        is_hex = 1'b1;
        if (c inside {["0":"9"]}) nib = 4'(c - "0");
        else if (c inside {["a":"f"]}) nib = 4'(c - "a" + 8'd10);
        else if (c inside {["A":"F"]}) nib = 4'(c - "A" + 8'd10);
        else is_hex = 1'b0;
        if (it.end_of_input || !is_hex) begin
          end_string(KIND_ERROR, ERR_HEX);
        end else begin
          hex_accum = {hex_accum[11:0], nib};
          if (hex_digits < 2'd3) begin
            hex_digits++;
          end else begin
            code = hex_accum;
            hex_digits = '0;
            hex_accum = '0;
            if (dec_mode == ST_HEX_FIRST) begin
              if (code inside {[16'hD800:16'hDBFF]}) begin
                hi_surr = code[9:0];
                dec_mode = ST_WANT_BS;
              end else begin
                add_utf8({5'b0, code});
                dec_mode = ST_NORMAL;
              end
            end else if (!(code inside {[16'hDC00:16'hDFFF]})) begin
              end_string(KIND_ERROR, ERR_LOW);
            end else begin
              add_utf8(21'h10000 + {1'b0, hi_surr, code[9:0]});
              clear_decoder();
            end
          end
        end
      end
      ST_WANT_BS: begin
        if (it.end_of_input || c != CH_BSLASH) end_string(KIND_ERROR, ERR_LOW);
        else dec_mode = ST_WANT_U;
      end
      ST_WANT_U: begin
        if (it.end_of_input || c != "u") begin
          end_string(KIND_ERROR, ERR_LOW);
        end else begin
          dec_mode = ST_HEX_LOW;
          hex_digits = '0;
          hex_accum = '0;
        end
      end
      default: begin
        if (it.end_of_input) begin
          end_string(KIND_ERROR, ERR_UNTERMINATED);
        end else if (c == it.close_quote) begin
          end_string(KIND_DONE, ERR_NONE);
        end else if (c == CH_BSLASH) begin
          dec_mode = ST_ESC;
        end else begin
          dec_mode = ST_NORMAL;
          add_result(c, KIND_DATA, ERR_NONE);
        end
      end
    endcase
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
  endfunction

  // Random string bodies.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic void put(input logic [7:0] c, input logic eoi);
    stim_row_t r;
    r.item.char_in = c;
    r.item.end_of_input = eoi;
    r.item.close_quote = cur_quote;
    r.typed = 1'b0;
    r.exp = '0;
    stim_q.push_back(r);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(n) - 8'd10;
  endfunction

  function automatic void put_hex4(input logic [15:0] v);
    put(CH_BSLASH, 1'b0);
    put("u", 1'b0);
    for (int i = 3; i >= 0; i--) put(hex_char(v[i*4 +: 4]), 1'b0);
  endfunction

  function automatic logic [15:0] rand_bmp();
    logic [15:0] v;
    case ($urandom_range(0, 4))
      0: v = 16'($urandom_range(0, 16'h7F));
      1: v = 16'($urandom_range(16'h80, 16'h7FF));
      2: v = BoundaryCodes[$urandom_range(0, 9)];
      default: begin
        do v = 16'($urandom_range(16'h800, 16'hFFFF));
        while (v inside {[16'hD800:16'hDBFF]});
      end
    endcase
    return v;
  endfunction

  function automatic void gen_string();
    int r;
    int ntok;
    int k;
    logic [7:0] c;
    logic [15:0] hi;
    logic [15:0] lo;
    r = $urandom_range(0, 99);
    if (r < 60) cur_quote = CH_DQUOTE;
    else if (r < 80) cur_quote = CH_SQUOTE;
    else if (r < 92) cur_quote = 8'($urandom_range(0, 255));
    else cur_quote = CH_BSLASH;
    ntok = $urandom_range(0, 8);
    for (int t = 0; t < ntok; t++) begin
      r = $urandom_range(0, 99);
      hi = 16'hD800 + 16'($urandom_range(0, 16'h3FF));
      lo = 16'hDC00 + 16'($urandom_range(0, 16'h3FF));
      if ($urandom_range(0, 9) == 0) begin
        hi = 16'hD800;
        lo = 16'hDC00;
      end
      if (r < 30) begin
        c = 8'($urandom_range(0, 255));
        if (c == cur_quote || c == CH_BSLASH) c = "a";
        put(c, 1'b0);
      end else if (r < 45) begin
        put(CH_BSLASH, 1'b0);
        put(EscLetters[$urandom_range(0, 7)], 1'b0);
      end else if (r < 62) begin
        put_hex4(rand_bmp());
      end else if (r < 78) begin
        put_hex4(hi);
        put_hex4(lo);
      end else if (r < 84) begin
        put(CH_BSLASH, 1'b0);
        do c = 8'($urandom_range(0, 255));
        while (c inside {8'h22, CH_BSLASH, 8'h2F, "b", "f", "n", "r", "t", "u"});
        put(c, 1'b0);
        return;
      end else if (r < 89) begin
        put(CH_BSLASH, 1'b0);
        put("u", 1'b0);
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++) put(hex_char(4'($urandom_range(0, 15))), 1'b0);
        do c = 8'($urandom_range(0, 255));
        while (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
        put(c, 1'b0);
        return;
      end else if (r < 95) begin
        put_hex4(hi);
        case ($urandom_range(0, 2))
          0: begin
            do c = 8'($urandom_range(0, 255));
            while (c == CH_BSLASH);
            put(c, 1'b0);
          end
          1: begin
            put(CH_BSLASH, 1'b0);
            do c = 8'($urandom_range(0, 255));
            while (c == "u");
            put(c, 1'b0);
          end
          default: begin
            do lo = 16'($urandom);
            while (lo inside {[16'hDC00:16'hDFFF]});
            put_hex4(lo);
          end
        endcase
        return;
      end else begin
        // The input ends in the middle of an escape.
        case ($urandom_range(0, 3))
          0: put(CH_BSLASH, 1'b0);
          1: begin
            put(CH_BSLASH, 1'b0);
            put("u", 1'b0);
            k = $urandom_range(0, 3);
            for (int i = 0; i < k; i++) put(hex_char(4'($urandom_range(0, 15))), 1'b0);
          end
          2: put_hex4(hi);
          default: begin
            put_hex4(hi);
            put(CH_BSLASH, 1'b0);
          end
        endcase
        put(8'($urandom_range(0, 255)), 1'b1);
        return;
      end
    end
    r = $urandom_range(0, 99);
    if (r < 85) begin
      put(cur_quote, 1'b0);
    end else if (r < 95) begin
      put(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      cur_quote = 8'($urandom_range(0, 255));
      put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input stim_row_t r, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= r.item;
    do @(posedge clk); while (in_stall);
    decode_char(r.item);
    if (r.typed) begin
      expected_decode_q.push_back(r.exp);
    end else begin
      foreach (step_q[i]) expected_decode_q.push_back(step_q[i]);
    end
    @(negedge clk);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (expected_decode_q.size() == 0) begin
      report_mismatch($sformatf("unexpected item byte %02h kind %0d error %0d last %0d",
                                got.out_byte, got.kind, got.error_kind, got.last));
      return;
    end
    want = expected_decode_q.pop_front();
    if (got.out_byte !== want.out_byte)
      report_mismatch($sformatf("byte %02h, want %02h", got.out_byte, want.out_byte));
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
    if (got.error_kind !== want.error_kind)
      report_mismatch($sformatf("error %0d, want %0d", got.error_kind, want.error_kind));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_item);
  end

  // Result side: random stalls, quiet stretches, and one long hold-off.
  initial begin
    int stall_left;
    int free_left;
    bit held;
    out_stall = 1'b0;
    stall_left = 0;
    free_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HoldAfter) begin
        held = 1'b1;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (free_left > 0) begin
          free_left--;
        end else begin
          stall_left = ((cycles / 400) % 4 == 0) ? 0 : pick_gap();
          free_left = $urandom_range(0, 10);
        end
      end
    end
  end

  initial begin
    dir_rows = '{
      '{'{"A", 1'b0, CH_DQUOTE}, 1'b1, '{8'h41, KIND_DATA, ERR_NONE, 1'b1}},
      '{'{8'h00, 1'b0, CH_DQUOTE}, 1'b1, '{8'h00, KIND_DATA, ERR_NONE, 1'b1}},
      '{'{8'hFF, 1'b0, CH_DQUOTE}, 1'b1, '{8'hFF, KIND_DATA, ERR_NONE, 1'b1}},
      '{'{CH_DQUOTE, 1'b0, CH_DQUOTE}, 1'b1, '{8'h00, KIND_DONE, ERR_NONE, 1'b1}},
      '{'{8'hFF, 1'b1, CH_DQUOTE}, 1'b1, '{8'h00, KIND_ERROR, ERR_UNTERMINATED, 1'b1}},
      '{'{CH_BSLASH, 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{"x", 1'b0, CH_DQUOTE}, 1'b1, '{8'h00, KIND_ERROR, ERR_ESCAPE, 1'b1}},
      '{'{CH_BSLASH, 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{CH_DQUOTE, 1'b0, CH_DQUOTE}, 1'b1, '{8'h22, KIND_DATA, ERR_NONE, 1'b1}},
      '{'{CH_BSLASH, 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{"u", 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{"D", 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{"B", 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{"F", 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{"F", 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{CH_BSLASH, 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{"u", 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{"d", 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{"f", 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{"f", 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{"f", 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{CH_BSLASH, 1'b0, CH_BSLASH}, 1'b1, '{8'h00, KIND_DONE, ERR_NONE, 1'b1}},
      '{'{CH_BSLASH, 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{8'h00, 1'b1, CH_DQUOTE}, 1'b1, '{8'h00, KIND_ERROR, ERR_ESCAPE, 1'b1}},
      '{'{CH_BSLASH, 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{"u", 1'b0, CH_DQUOTE}, 1'b0, '0},
      '{'{"G", 1'b0, CH_DQUOTE}, 1'b1, '{8'h00, KIND_ERROR, ERR_HEX, 1'b1}}
    };
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i], 1'b0);
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_decode_q.size() != 0) @(negedge clk);

    while (stim_q.size() < NumRandItems) gen_string();
    foreach (stim_q[i]) send_item(stim_q[i], (i / 50) % 4 == 1);
    in_valid <= 1'b0;

    while (expected_decode_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
